// File: hw/rtl/swm_pkg.sv
// swm_pkg: shared sizes, codes, constants and the quarter-wave cosine table builder
// for the selectable window multiplier. No dependencies.

package swm_pkg;

  localparam int MAX_FRAME   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int COS_DEPTH   = 1024;

  localparam int COS_AW = $clog2(COS_DEPTH);
  localparam int LEN_W  = 13;
  localparam int POS_W  = $clog2(MAX_FRAME);
  localparam int PH_W   = 16;
  localparam int QUO_W  = PH_W + 1;
  localparam int DVD_W  = POS_W + PH_W;
  localparam int CNT_W  = $clog2(QUO_W + 1);
  localparam int COS_W  = PH_W + 2;
  localparam int MUL_W  = 2 * COS_W;
  localparam int ACC_W  = PH_W + PH_W + 3;

  localparam logic [QUO_W-1:0] UNITY = QUO_W'(1) << PH_W;

  localparam logic [PH_W-1:0] HAM_C0 = 16'd35389;
  localparam logic [PH_W-1:0] HAM_C1 = 16'd30147;
  localparam logic [PH_W-1:0] BLK_C0 = 16'd27525;
  localparam logic [PH_W-1:0] BLK_C1 = 16'd32768;
  localparam logic [PH_W-1:0] BLK_C2 = 16'd5243;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic REG_WIN_TYPE  = 1'b0;
  localparam logic REG_FRAME_LEN = 1'b1;

  typedef enum logic [1:0] {
    WIN_RECT     = 2'd0,
    WIN_HAMMING  = 2'd1,
    WIN_BLACKMAN = 2'd2,
    WIN_BARTLETT = 2'd3
  } win_t;

  typedef logic [COS_DEPTH-1:0][PH_W-1:0] cos_rom_t;

  // cos(pi/2 * k / depth) in Q0.16 by a ten-term series in Q30
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned e;
    longint acc;
    rom = '0;
    for (int k = 0; k < COS_DEPTH; k++) begin
      a = (HALF_PI_Q30 * 64'(k) + 64'(COS_DEPTH / 2)) / 64'(COS_DEPTH);
      a2 = (a * a) >> 30;
      term = 64'd1 << 30;
      acc = longint'(term);
      for (int m = 1; m <= 9; m++) begin
        term = ((term * a2) >> 30) / 64'((2 * m - 1) * (2 * m));
        if ((m % 2) == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      e = (longint'(acc) + 64'd8192) >> 14;
      if (e > 64'd65535) begin
        e = 64'd65535;
      end
      rom[k] = e[PH_W-1:0];
    end
    return rom;
  endfunction

endpackage

// File: hw/rtl/swm_div.sv
// swm_div: restoring divider, one quotient bit per cycle, for the window phase.
// Depends on swm_pkg.

module swm_div import swm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [POS_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic [POS_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [POS_W:0]   trial;
  logic [POS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[QUO_W-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = POS_W'(dividend[DVD_W-1:QUO_W]);
      quo_nxt  = dividend[QUO_W-1:0];
      cnt_nxt  = CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/swm_cos.sv
// swm_cos: full-turn cosine in signed Q1.16 from a 16-bit phase, read from a
// registered quarter-wave table. Depends on swm_pkg.

module swm_cos import swm_pkg::*; (
  input  logic                    clk,
  input  logic [PH_W-1:0]         phase,
  output logic signed [COS_W-1:0] cos_val
);

  localparam cos_rom_t CosRom = build_cos_rom();

  logic [1:0]                quad;
  logic [PH_W-3:0]           frac;
  logic [PH_W-2+COS_AW:0]    scaled;
  logic [COS_AW:0]           idx;
  logic [COS_AW:0]           sel;
  logic [PH_W-1:0]           rom_q_r;
  logic                      peak_r;
  logic                      null_r;
  logic                      neg_r;
  logic [QUO_W-1:0]          mag;

  always_comb begin
    quad   = phase[PH_W-1:PH_W-2];
    frac   = phase[PH_W-3:0];
    scaled = {1'b0, frac, {COS_AW{1'b0}}} + ((PH_W - 1 + COS_AW)'(1) << (PH_W - 3));
    idx    = scaled[PH_W-2 +: COS_AW+1];
    sel    = quad[0] ? ((COS_AW+1)'(COS_DEPTH) - idx) : idx;
  end

  always_ff @(posedge clk) begin
    rom_q_r <= CosRom[sel[COS_AW-1:0]];
    peak_r  <= (sel == '0);
    null_r  <= sel[COS_AW];
    neg_r   <= quad[0] ^ quad[1];
  end

  always_comb begin
    if (peak_r) begin
      mag = UNITY;
    end else if (null_r) begin
      mag = '0;
    end else begin
      mag = {1'b0, rom_q_r};
    end
    cos_val = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// File: hw/rtl/selectable_window_multiplier.sv
// selectable_window_multiplier: top level, sequencer, shared multiply-accumulate
// unit, output register and APB register file. Depends on swm_pkg, swm_div, swm_cos.
//
// Each sample is scaled by the window coefficient for its place in the frame
// and rounded half away from zero; frame_last marks the final sample of each
// frame. Windows are rectangular, Hamming, Blackman and Bartlett, with the
// frame length up to 4096 (larger values act as 4096, below 2 samples pass
// straight through with frame_last low). One sample is worked on at a time.
// The 17-step restoring divider forms n/(N-1), or for Bartlett the triangle
// distance over N-1; the single 18x18 multiply-accumulate unit serves every
// product, with the registered cosine table feeding the Hamming and Blackman
// terms. A result waiting in the output register does not stop the next
// sample from being accepted, but a finished result that cannot move into it
// does. Any register write restarts the frame.

module selectable_window_multiplier import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_frame_last,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_LOOK1 = 9'b000000100,
    S_MAC1  = 9'b000001000,
    S_LOOK2 = 9'b000010000,
    S_MAC2  = 9'b000100000,
    S_WGT   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_RND   = 9'b100000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           done_r, done_nxt;
  win_t                           type_r, type_nxt;
  logic [LEN_W-1:0]               flen_r, flen_nxt;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic                           neg_r, neg_nxt;
  logic [SAMPLE_BITS-1:0]         mag_r, mag_nxt;
  logic                           last_r, last_nxt;
  logic [SAMPLE_BITS-1:0]         res_r, res_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic [QUO_W-1:0]               w_r, w_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]         out_sample_r, out_sample_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           cfg_wr;
  logic                           accept;
  logic [LEN_W-1:0]               len_c;
  logic [POS_W-1:0]               span_c;
  logic [POS_W-1:0]               n_c;
  logic                           last_c;
  logic [LEN_W-1:0]               twice_c;
  logic [LEN_W-1:0]               dist_c;
  logic [POS_W-1:0]               tri_c;
  logic [DVD_W-1:0]               dividend;
  logic                           div_start;
  logic                           div_done;
  logic [QUO_W-1:0]               quotient;
  logic [PH_W-1:0]                phase;
  logic signed [COS_W-1:0]        cos_val;
  logic signed [COS_W-1:0]        mul_a;
  logic signed [COS_W-1:0]        mul_b;
  logic signed [MUL_W-1:0]        product;
  logic [ACC_W-PH_W-1:0]          w_round;
  logic [PH_W+1:0]                r_round;
  logic [SAMPLE_BITS-1:0]         r_signed;
  logic [SAMPLE_BITS-1:0]         mag_in;
  logic                           out_free;

  assign cfg_wr   = cfg_psel & cfg_penable & cfg_pwrite;
  assign in_ready = (state_r == S_IDLE) && !done_r;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // frame position and phase numerator
  always_comb begin
    len_c   = (flen_r > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : flen_r;
    span_c  = POS_W'(len_c - LEN_W'(1));
    n_c     = ({1'b0, pos_r} >= len_c) ? '0 : pos_r;
    last_c  = ({1'b0, n_c} == (len_c - LEN_W'(1)));
    twice_c = {n_c, 1'b0};
    dist_c  = (twice_c > {1'b0, span_c}) ? (twice_c - {1'b0, span_c})
                                         : ({1'b0, span_c} - twice_c);
    tri_c   = span_c - POS_W'(dist_c);
    if (type_r == WIN_BARTLETT) begin
      dividend = {tri_c, {PH_W{1'b0}}} + DVD_W'(span_c >> 1);
    end else begin
      dividend = {n_c, {PH_W{1'b0}}} + DVD_W'(span_c >> 1);
    end
    div_start = accept && (len_c >= LEN_W'(2)) && (type_r != WIN_RECT);
  end

  swm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span_c),
    .done     (div_done),
    .quotient (quotient)
  );

  assign phase = (state_r == S_LOOK2) ? {quotient[PH_W-2:0], 1'b0} : quotient[PH_W-1:0];

  swm_cos u_cos (
    .clk     (clk),
    .phase   (phase),
    .cos_val (cos_val)
  );

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MAC1: begin
        mul_a = (type_r == WIN_HAMMING) ? -$signed({2'b00, HAM_C1})
                                        : -$signed({2'b00, BLK_C1});
        mul_b = cos_val;
      end
      S_MAC2: begin
        mul_a = $signed({2'b00, BLK_C2});
        mul_b = cos_val;
      end
      S_MUL: begin
        mul_a = $signed(COS_W'(mag_r));
        mul_b = $signed({1'b0, w_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = mul_a * mul_b;
  end

  always_comb begin
    w_round  = acc_r[ACC_W-1:PH_W] + (ACC_W-PH_W)'(acc_r[PH_W-1]);
    r_round  = acc_r[2*PH_W+1:PH_W] + (PH_W+2)'(acc_r[PH_W-1]);
    r_signed = neg_r ? SAMPLE_BITS'(-r_round) : SAMPLE_BITS'(r_round);
    mag_in   = in_sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample_in)
                                           : SAMPLE_BITS'(in_sample_in);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    done_nxt       = done_r;
    type_nxt       = type_r;
    flen_nxt       = flen_r;
    pos_nxt        = pos_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    last_nxt       = last_r;
    res_nxt        = res_r;
    acc_nxt        = acc_r;
    w_nxt          = w_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt  = in_sample_in[SAMPLE_BITS-1];
          mag_nxt  = mag_in;
          if (len_c < LEN_W'(2)) begin
            res_nxt  = in_sample_in;
            last_nxt = 1'b0;
            pos_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            last_nxt = last_c;
            pos_nxt  = last_c ? '0 : (n_c + POS_W'(1));
            if (type_r == WIN_RECT) begin
              w_nxt     = UNITY;
              state_nxt = S_MUL;
            end else begin
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (type_r == WIN_BARTLETT) begin
            w_nxt     = quotient;
            state_nxt = S_MUL;
          end else begin
            acc_nxt   = (type_r == WIN_HAMMING) ? $signed(ACC_W'({HAM_C0, {PH_W{1'b0}}}))
                                                : $signed(ACC_W'({BLK_C0, {PH_W{1'b0}}}));
            state_nxt = S_LOOK1;
          end
        end
      end
      S_LOOK1: begin
        state_nxt = S_MAC1;
      end
      S_MAC1: begin
        acc_nxt   = acc_r + ACC_W'(product);
        state_nxt = (type_r == WIN_BLACKMAN) ? S_LOOK2 : S_WGT;
      end
      S_LOOK2: begin
        state_nxt = S_MAC2;
      end
      S_MAC2: begin
        acc_nxt   = acc_r + ACC_W'(product);
        state_nxt = S_WGT;
      end
      S_WGT: begin
        if (acc_r[ACC_W-1]) begin
          w_nxt = '0;
        end else if (w_round > (ACC_W-PH_W)'(UNITY)) begin
          w_nxt = UNITY;
        end else begin
          w_nxt = QUO_W'(w_round);
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt   = ACC_W'(product);
        state_nxt = S_RND;
      end
      S_RND: begin
        res_nxt   = r_signed;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hand the finished result to the output register
    if (done_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = res_r;
      out_last_nxt   = last_r;
      done_nxt       = 1'b0;
    end

    if (cfg_wr) begin
      pos_nxt = '0;
      case (cfg_paddr[2])
        REG_WIN_TYPE:  type_nxt = win_t'(cfg_pwdata[1:0]);
        REG_FRAME_LEN: flen_nxt = cfg_pwdata[LEN_W-1:0];
        default:       flen_nxt = flen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    last_r       <= last_nxt;
    res_r        <= res_nxt;
    acc_r        <= acc_nxt;
    w_r          <= w_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= 1'b0;
      type_r      <= WIN_RECT;
      flen_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      type_r      <= type_nxt;
      flen_r      <= flen_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_WIN_TYPE:  cfg_prdata = 32'(type_r);
      REG_FRAME_LEN: cfg_prdata = 32'(flen_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg_pready     = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_frame_last = out_last_r;

endmodule
